>>> hw/rtl/i2c_bit_bang_master_assert.svh
// Assertion macros used by the I2C bit-level master core.
`ifndef I2C_BIT_BANG_MASTER_ASSERT_SVH
`define I2C_BIT_BANG_MASTER_ASSERT_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`else

`define ASSERT_IMP(name, clk, rst_n, ante, cons)
`define ASSERT_NXT(name, clk, rst_n, ante, cons)

`endif

`endif

>>> hw/rtl/i2cbb_pkg.sv
// Package with the types, constants and line-level helper of the I2C bit-level master.
package i2cbb_pkg;

	// Command codes.
	typedef enum logic [2:0] {
		MODE_START  = 3'd0,
		MODE_STOP   = 3'd1,
		MODE_WRITE  = 3'd2,
		MODE_READ   = 3'd3,
		MODE_GETACK = 3'd4,
		MODE_PUTACK = 3'd5
	} mode_t;

	// Unit phase in which SCL is high for a bit.
	localparam logic [1:0] PHASE_HIGH = 2'd2;
	localparam logic [1:0] PHASE_LAST_STOP = 2'd3;
	localparam logic [3:0] BITS_PER_BYTE = 4'd8;
	localparam logic [15:0] DELAY_RESET = 16'd100;

	// One input word, as held in the input register.
	typedef struct packed {
		logic       cmd_valid;
		logic [2:0] mode;
		logic [7:0] tx_byte;
		logic       ack_to_send;
		logic       sda_in;
	} cmd_t;

	// One result word.
	typedef struct packed {
		logic       scl_level;
		logic       sda_level;
		logic       busy_res;
		logic       done_res;
		logic [7:0] rx_byte;
		logic       ack_seen;
	} res_t;

	// Line levels and updated registers on entering a delay unit.
	typedef struct packed {
		logic       scl;
		logic       sda;
		logic [7:0] shift;
		logic       ack;
	} unit_t;

	function automatic unit_t enter_unit(mode_t m, logic [1:0] ph, logic [3:0] bi,
		logic [7:0] sh, logic sda_in, logic ack);
		unit_t u;
		u.scl   = (ph == PHASE_HIGH);
		u.sda   = 1'b1;
		u.shift = sh;
		u.ack   = ack;
		case (m)
			MODE_START: begin
				u.scl = 1'b1;
				u.sda = (ph == 2'd0);
			end
			MODE_STOP: begin
				u.scl = 1'b1;
				u.sda = (ph != 2'd0);
			end
			MODE_WRITE: begin
				// MSB first: bit 7 - index.
				u.sda = sh[~bi[2:0]];
			end
			MODE_READ: begin
				if (ph == PHASE_HIGH) begin
					u.shift = {sh[6:0], sda_in};
				end
			end
			MODE_GETACK: begin
				if (ph == PHASE_HIGH) begin
					u.ack = sda_in;
				end
			end
			MODE_PUTACK: begin
				u.sda = sh[0];
			end
			default: begin
			end
		endcase
		return u;
	endfunction

endpackage

>>> hw/rtl/i2cbb_cmd_if.sv
// Handshake interface carrying one command word per tick.
interface i2cbb_cmd_if;
	logic       valid;
	logic       ready;
	logic       cmd_valid;
	logic [2:0] mode;
	logic [7:0] tx_byte;
	logic       ack_to_send;
	logic       sda_in;

	modport source (output valid, cmd_valid, mode, tx_byte, ack_to_send, sda_in,
		input ready);
	modport sink (input valid, cmd_valid, mode, tx_byte, ack_to_send, sda_in,
		output ready);
endinterface

>>> hw/rtl/i2cbb_res_if.sv
// Handshake interface carrying one result word per tick.
interface i2cbb_res_if;
	logic       valid;
	logic       ready;
	logic       scl_level;
	logic       sda_level;
	logic       busy_res;
	logic       done_res;
	logic [7:0] rx_byte;
	logic       ack_seen;

	modport source (output valid, scl_level, sda_level, busy_res, done_res, rx_byte,
		ack_seen, input ready);
	modport sink (input valid, scl_level, sda_level, busy_res, done_res, rx_byte,
		ack_seen, output ready);
endinterface

>>> hw/rtl/i2cbb_core.sv
// Sequencer state and next-state logic of the I2C bit-level master.
`include "i2c_bit_bang_master_assert.svh"

module i2cbb_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               advance,
	input  i2cbb_pkg::cmd_t    cmd_s1,
	input  logic [15:0]        delay_ticks,
	output i2cbb_pkg::res_t    res_d
);
	import i2cbb_pkg::*;

	mode_t       mode_q, mode_d;
	logic        busy_q, busy_d;
	logic [1:0]  phase_q, phase_d, phase_nx;
	logic [3:0]  bit_q, bit_d, bit_nx;
	logic [15:0] tick_q, tick_d, tick_inc, units;
	logic [7:0]  shift_q, shift_d;
	logic [7:0]  rx_q, rx_d;
	logic        scl_q, scl_d, sda_q, sda_d, ack_q, ack_d;
	logic        done_d, unit_end;
	mode_t       new_mode;
	logic [7:0]  new_shift;
	unit_t       u;

	// A zero delay counts as one tick per unit.
	assign units    = (delay_ticks == 16'd0) ? 16'd1 : delay_ticks;
	assign tick_inc = tick_q + 16'd1;
	assign new_mode = mode_t'(cmd_s1.mode);

	// Shift register load value for a new command.
	always_comb begin
		case (new_mode)
			MODE_WRITE:  new_shift = cmd_s1.tx_byte;
			MODE_PUTACK: new_shift = {7'd0, cmd_s1.ack_to_send};
			default:     new_shift = 8'd0;
		endcase
	end

	// Next state for one tick.
	always_comb begin
		mode_d   = mode_q;
		busy_d   = busy_q;
		phase_d  = phase_q;
		bit_d    = bit_q;
		tick_d   = tick_q;
		shift_d  = shift_q;
		rx_d     = rx_q;
		scl_d    = scl_q;
		sda_d    = sda_q;
		ack_d    = ack_q;
		done_d   = 1'b0;
		phase_nx = phase_q;
		bit_nx   = bit_q;
		unit_end = 1'b0;
		u        = enter_unit(mode_q, phase_q, bit_q, shift_q, cmd_s1.sda_in, ack_q);
		if (busy_q) begin
			if (tick_inc >= units) begin
				tick_d = 16'd0;
				// Step to the next delay unit and see whether the sequence ends.
				case (mode_q)
					MODE_START: begin
						phase_nx = phase_q + 2'd1;
						unit_end = (phase_nx >= PHASE_HIGH);
					end
					MODE_STOP: begin
						phase_nx = phase_q + 2'd1;
						unit_end = (phase_nx >= PHASE_LAST_STOP);
					end
					default: begin
						if (phase_q < PHASE_HIGH) begin
							phase_nx = phase_q + 2'd1;
						end else begin
							phase_nx = 2'd0;
							bit_nx   = bit_q + 4'd1;
							unit_end = (mode_q == MODE_WRITE || mode_q == MODE_READ) ?
								(bit_nx >= BITS_PER_BYTE) : 1'b1;
						end
					end
				endcase
				if (unit_end) begin
					// Sequence complete: final levels and done pulse.
					case (mode_q)
						MODE_START: begin
							scl_d = 1'b0;
							sda_d = 1'b0;
						end
						MODE_STOP: begin
							scl_d = 1'b1;
							sda_d = 1'b1;
						end
						MODE_READ: begin
							scl_d = 1'b0;
							rx_d  = shift_q;
						end
						default: begin
							scl_d = 1'b0;
						end
					endcase
					busy_d  = 1'b0;
					phase_d = 2'd0;
					bit_d   = 4'd0;
					done_d  = 1'b1;
				end else begin
					u       = enter_unit(mode_q, phase_nx, bit_nx, shift_q, cmd_s1.sda_in,
						ack_q);
					phase_d = phase_nx;
					bit_d   = bit_nx;
					scl_d   = u.scl;
					sda_d   = u.sda;
					shift_d = u.shift;
					ack_d   = u.ack;
				end
			end else begin
				tick_d = tick_inc;
			end
		end else if (cmd_s1.cmd_valid && new_mode <= MODE_PUTACK) begin
			// Take a new command; this tick is the first of its first unit.
			u       = enter_unit(new_mode, 2'd0, 4'd0, new_shift, cmd_s1.sda_in, ack_q);
			mode_d  = new_mode;
			busy_d  = 1'b1;
			phase_d = 2'd0;
			bit_d   = 4'd0;
			tick_d  = 16'd0;
			scl_d   = u.scl;
			sda_d   = u.sda;
			shift_d = u.shift;
			ack_d   = u.ack;
		end
	end

	// State registers, updated once per word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_START;
			busy_q  <= 1'b0;
			phase_q <= 2'd0;
			bit_q   <= 4'd0;
			tick_q  <= 16'd0;
			shift_q <= 8'd0;
			rx_q    <= 8'd0;
			scl_q   <= 1'b1;
			sda_q   <= 1'b1;
			ack_q   <= 1'b1;
		end else if (advance) begin
			mode_q  <= mode_d;
			busy_q  <= busy_d;
			phase_q <= phase_d;
			bit_q   <= bit_d;
			tick_q  <= tick_d;
			shift_q <= shift_d;
			rx_q    <= rx_d;
			scl_q   <= scl_d;
			sda_q   <= sda_d;
			ack_q   <= ack_d;
		end
	end

	// Result word after this tick's update.
	assign res_d = '{scl_level: scl_d, sda_level: sda_d, busy_res: busy_d,
		done_res: done_d, rx_byte: rx_d, ack_seen: ack_d};

	`ASSERT_IMP(a_idle_tick_clear, clk, arst_n, !busy_q, tick_q == 16'd0)
	`ASSERT_IMP(a_phase_range, clk, arst_n, busy_q, phase_q != PHASE_LAST_STOP)
	`ASSERT_IMP(a_bit_range, clk, arst_n, busy_q, bit_q < BITS_PER_BYTE)
	`ASSERT_NXT(a_done_idles, clk, arst_n, advance && done_d, !busy_q && phase_q == 2'd0)

endmodule

>>> hw/rtl/i2c_bit_bang_master.sv
// A word is held in the input register, its result then in the result register.
// Throughput: one word per cycle; the input register and the result register
// form a two-stage pipeline and only a stalled result register holds back input.
// Reset: arst_n clears both stages, releases SCL and SDA high, sets the
// acknowledge to 1 and the delay to 100 ticks per unit.
module i2c_bit_bang_master (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	i2cbb_cmd_if.sink   cmd,
	i2cbb_res_if.source res
);
	import i2cbb_pkg::*;

	logic [15:0] delay_q;
	logic        valid_s1, valid_s2;
	cmd_t        cmd_s1;
	res_t        res_s2, res_d;
	logic        ready_s1, advance;

	// Stage 1 moves on when the result register is free or being drained.
	assign ready_s1  = !valid_s2 || res.ready;
	assign advance   = valid_s1 && ready_s1;
	assign cmd.ready = !valid_s1 || ready_s1;

	// Delay register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q <= DELAY_RESET;
		end else if (cfg_we) begin
			delay_q <= cfg_wdata;
		end
	end

	// Pipeline valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (cmd.ready) begin
				valid_s1 <= cmd.valid;
			end
			if (ready_s1) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// Input and result words.
	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			cmd_s1 <= '{cmd_valid: cmd.cmd_valid, mode: cmd.mode, tx_byte: cmd.tx_byte,
				ack_to_send: cmd.ack_to_send, sda_in: cmd.sda_in};
		end
		if (advance) begin
			res_s2 <= res_d;
		end
	end

	i2cbb_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (advance),
		.cmd_s1      (cmd_s1),
		.delay_ticks (delay_q),
		.res_d       (res_d)
	);

	// Result port.
	assign res.valid     = valid_s2;
	assign res.scl_level = res_s2.scl_level;
	assign res.sda_level = res_s2.sda_level;
	assign res.busy_res  = res_s2.busy_res;
	assign res.done_res  = res_s2.done_res;
	assign res.rx_byte   = res_s2.rx_byte;
	assign res.ack_seen  = res_s2.ack_seen;

endmodule

>>> sim/i2c_bit_bang_master_checker.sv
// Checker for the I2C bit-level master: predicts every result word and compares it with the block.
`timescale 1ns / 100ps
module i2c_bit_bang_master_checker
	import i2cbb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	i2cbb_cmd_if        cmd,
	i2cbb_res_if        res,
	output int unsigned fail_count,
	output int unsigned words_in_flight
);

	localparam int unsigned SHOWN_ERRORS = 10;

	// Predicted bus state, kept apart from the block.
	logic [15:0] unit_ticks_cfg;
	mode_t       cur_mode;
	logic        busy;
	logic [1:0]  phase;
	logic [3:0]  bit_cnt;
	logic [15:0] tick_cnt;
	logic [7:0]  shift;
	logic [7:0]  rx_hold;
	logic        scl;
	logic        sda;
	logic        ack;

	res_t        expected_words[$];
	res_t        got;
	res_t        want;
	int unsigned errors = 0;

	// Line levels for the delay unit being entered; SDA is sampled on the SCL-high unit.
	task automatic drive_unit_levels(input logic sda_in);
		scl = (phase == PHASE_HIGH);
		case (cur_mode)
			MODE_START: begin
				scl = 1'b1;
				sda = (phase == 2'd0);
			end
			MODE_STOP: begin
				scl = 1'b1;
				sda = (phase != 2'd0);
			end
			MODE_WRITE: begin
				// Most significant bit goes out first.
				sda = shift[3'd7 - bit_cnt[2:0]];
			end
			MODE_READ: begin
				sda = 1'b1;
				if (phase == PHASE_HIGH) begin
					shift = {shift[6:0], sda_in};
				end
			end
			MODE_GETACK: begin
				sda = 1'b1;
				if (phase == PHASE_HIGH) begin
					ack = sda_in;
				end
			end
			default: begin
				sda = shift[0];
			end
		endcase
	endtask

	// One clock tick of the bus sequencer for an accepted word.
	task automatic bus_tick(input cmd_t w);
		logic [15:0] units;
		logic        seq_end;
		logic        done;
		units   = (unit_ticks_cfg == 16'd0) ? 16'd1 : unit_ticks_cfg;
		seq_end = 1'b0;
		done    = 1'b0;
		if (busy) begin
			tick_cnt = tick_cnt + 16'd1;
			if (tick_cnt >= units) begin
				tick_cnt = '0;
				// Move on to the next unit and find out whether the sequence is over.
				if (cur_mode == MODE_START) begin
					phase   = phase + 2'd1;
					seq_end = (phase == 2'd2);
				end else if (cur_mode == MODE_STOP) begin
					phase   = phase + 2'd1;
					seq_end = (phase == PHASE_LAST_STOP);
				end else if (phase != PHASE_HIGH) begin
					phase = phase + 2'd1;
				end else begin
					phase   = 2'd0;
					bit_cnt = bit_cnt + 4'd1;
					seq_end = (cur_mode == MODE_WRITE || cur_mode == MODE_READ) ?
						(bit_cnt == BITS_PER_BYTE) : 1'b1;
				end
				if (seq_end) begin
					// Final levels: a start leaves both lines low, a stop releases both.
					if (cur_mode == MODE_START) begin
						scl = 1'b0;
						sda = 1'b0;
					end else if (cur_mode == MODE_STOP) begin
						scl = 1'b1;
						sda = 1'b1;
					end else begin
						scl = 1'b0;
						if (cur_mode == MODE_READ) begin
							rx_hold = shift;
						end
					end
					busy     = 1'b0;
					phase    = 2'd0;
					bit_cnt  = 4'd0;
					tick_cnt = '0;
					done     = 1'b1;
				end else begin
					drive_unit_levels(w.sda_in);
				end
			end
		end else if (w.cmd_valid && w.mode <= MODE_PUTACK) begin
			// A new command starts its first unit on the accepting tick.
			cur_mode = mode_t'(w.mode);
			busy     = 1'b1;
			phase    = 2'd0;
			bit_cnt  = 4'd0;
			tick_cnt = '0;
			if (cur_mode == MODE_WRITE) begin
				shift = w.tx_byte;
			end else if (cur_mode == MODE_PUTACK) begin
				shift = {7'd0, w.ack_to_send};
			end else begin
				shift = 8'd0;
			end
			drive_unit_levels(w.sda_in);
		end
		expected_words.push_back(res_t'({scl, sda, busy, done, rx_hold, ack}));
	endtask

	// Watch both channels and the register port; compare before predicting the new word.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_ticks_cfg = DELAY_RESET;
			cur_mode       = MODE_START;
			busy           = 1'b0;
			phase          = 2'd0;
			bit_cnt        = 4'd0;
			tick_cnt       = '0;
			shift          = 8'd0;
			rx_hold        = 8'd0;
			scl            = 1'b1;
			sda            = 1'b1;
			ack            = 1'b1;
			expected_words.delete();
		end else begin
			if (cfg_we) begin
				unit_ticks_cfg = cfg_wdata;
			end
			if (res.valid && res.ready) begin
				got = {res.scl_level, res.sda_level, res.busy_res, res.done_res, res.rx_byte,
					res.ack_seen};
				if (expected_words.size() == 0) begin
					errors++;
					if (errors <= SHOWN_ERRORS) begin
						$display("%0t: result word with none expected: scl %0b sda %0b busy %0b done %0b rx %02h ack %0b",
							$realtime, got.scl_level, got.sda_level, got.busy_res, got.done_res,
							got.rx_byte, got.ack_seen);
					end
				end else begin
					want = expected_words.pop_front();
					if (got.scl_level !== want.scl_level || got.sda_level !== want.sda_level ||
						got.busy_res !== want.busy_res || got.done_res !== want.done_res ||
						got.rx_byte !== want.rx_byte || got.ack_seen !== want.ack_seen) begin
						errors++;
						if (errors <= SHOWN_ERRORS) begin
							$display("%0t: result word mismatch: expected scl %0b sda %0b busy %0b done %0b rx %02h ack %0b",
								$realtime, want.scl_level, want.sda_level, want.busy_res,
								want.done_res, want.rx_byte, want.ack_seen);
							$display("%0t:                          got scl %0b sda %0b busy %0b done %0b rx %02h ack %0b",
								$realtime, got.scl_level, got.sda_level, got.busy_res,
								got.done_res, got.rx_byte, got.ack_seen);
						end
					end
				end
			end
			if (cmd.valid && cmd.ready) begin
				bus_tick({cmd.cmd_valid, cmd.mode, cmd.tx_byte, cmd.ack_to_send, cmd.sda_in});
			end
		end
		fail_count      <= errors;
		words_in_flight <= expected_words.size();
	end

endmodule

>>> sim/i2c_bit_bang_master_tb.sv
// Testbench top for the I2C bit-level master: clock, reset, stimulus, pacing and the verdict.
`timescale 1ns / 100ps
module i2c_bit_bang_master_tb;
	import i2cbb_pkg::*;

	localparam int          IDLE_PCT     = 33;
	localparam int unsigned HOLD_AT      = 600;
	localparam int          HOLD_CYCLES  = 200;
	localparam int unsigned STEADY_FROM  = 900;
	localparam int unsigned STEADY_TO    = 1200;
	localparam int unsigned QUIET_LIMIT  = 4000;
	localparam int          SETTLE       = 8;
	localparam logic [2:0]  MODE_UNDEF_A = 3'd6;
	localparam logic [2:0]  MODE_UNDEF_B = 3'd7;

	typedef enum logic [1:0] {
		SDA_LOW,
		SDA_HIGH,
		SDA_RANDOM
	} sda_drive_e;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [15:0] cfg_wdata;
	logic        steady;
	int unsigned fail_count;
	int unsigned words_in_flight;
	int unsigned word_count = 0;
	int unsigned quiet_cycles = 0;
	int unsigned ticks_per_unit = 100;
	bit          held_off = 1'b0;

	i2cbb_cmd_if cmd_ch ();
	i2cbb_res_if res_ch ();

	i2c_bit_bang_master u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd_ch),
		.res       (res_ch)
	);

	i2c_bit_bang_master_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.cmd             (cmd_ch),
		.res             (res_ch),
		.fail_count      (fail_count),
		.words_in_flight (words_in_flight)
	);

	// Clock and a single reset at the start.
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
	end

	// A window of words in which neither side idles.
	assign steady = (word_count >= STEADY_FROM) && (word_count < STEADY_TO);

	// Word count and a watchdog on cycles in which no word moves.
	always @(posedge clk) begin
		if (cmd_ch.valid && cmd_ch.ready) begin
			word_count <= word_count + 1;
		end
		if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("i2c_bit_bang_master_tb NOT OK");
			$finish;
		end
	end

	// Result side: random stalls, one long hold-off so that the input backs up.
	initial begin
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (!held_off && word_count >= HOLD_AT) begin
				held_off = 1'b1;
				res_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				res_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	function automatic logic pick_sda(input sda_drive_e drive);
		case (drive)
			SDA_LOW:  return 1'b0;
			SDA_HIGH: return 1'b1;
			default:  return 1'($urandom_range(1));
		endcase
	endfunction

	// Delay units that a command occupies on the bus.
	function automatic int units_of(input logic [2:0] op);
		case (op)
			MODE_START:                           return 2;
			MODE_STOP, MODE_GETACK, MODE_PUTACK:  return 3;
			MODE_WRITE, MODE_READ:                return 24;
			default:                              return 0;
		endcase
	endfunction

	// Offer one word, after a random gap, and wait until it is taken.
	task automatic send_word(input cmd_t w);
		if (!steady) begin
			while ($urandom_range(99) < IDLE_PCT) begin
				cmd_ch.valid <= 1'b0;
				@(posedge clk);
			end
		end
		cmd_ch.valid       <= 1'b1;
		cmd_ch.cmd_valid   <= w.cmd_valid;
		cmd_ch.mode        <= w.mode;
		cmd_ch.tx_byte     <= w.tx_byte;
		cmd_ch.ack_to_send <= w.ack_to_send;
		cmd_ch.sda_in      <= w.sda_in;
		do @(posedge clk); while (!cmd_ch.ready);
	endtask

	// Issue a command and then the idle words that carry it to completion.
	// Idle words hold a command request with the given chance, which the busy block ignores.
	task automatic bus_command(input logic [2:0] op, input logic [7:0] tx, input logic ack_lvl,
		input sda_drive_e drive, input int noise_pct);
		cmd_t w;
		int   span;
		w.cmd_valid   = 1'b1;
		w.mode        = op;
		w.tx_byte     = tx;
		w.ack_to_send = ack_lvl;
		w.sda_in      = pick_sda(drive);
		send_word(w);
		span = units_of(op) * ticks_per_unit;
		repeat (span) begin
			w.cmd_valid   = ($urandom_range(99) < noise_pct);
			w.mode        = 3'($urandom_range(7));
			w.tx_byte     = 8'($urandom);
			w.ack_to_send = 1'($urandom_range(1));
			w.sda_in      = pick_sda(drive);
			send_word(w);
		end
	endtask

	// Words with every field random.
	task automatic stray_words(input int count);
		cmd_t w;
		repeat (count) begin
			w.cmd_valid   = 1'($urandom_range(1));
			w.mode        = 3'($urandom_range(7));
			w.tx_byte     = 8'($urandom);
			w.ack_to_send = 1'($urandom_range(1));
			w.sda_in      = 1'($urandom_range(1));
			send_word(w);
		end
	endtask

	// Well-formed bus transfers with random content, with stray words between them.
	task automatic random_transfers(input int unsigned words);
		int unsigned stop_at;
		stop_at = word_count + words;
		while (word_count < stop_at) begin
			if ($urandom_range(99) < 10) begin
				stray_words($urandom_range(1, 4));
			end else begin
				bus_command(MODE_START, 8'($urandom), 1'($urandom_range(1)), SDA_RANDOM, 10);
				bus_command(MODE_WRITE, 8'($urandom), 1'($urandom_range(1)), SDA_RANDOM, 10);
				bus_command(MODE_GETACK, 8'($urandom), 1'($urandom_range(1)), SDA_RANDOM, 10);
				repeat ($urandom_range(1, 3)) begin
					if ($urandom_range(1)) begin
						bus_command(MODE_WRITE, 8'($urandom), 1'($urandom_range(1)), SDA_RANDOM, 10);
						bus_command(MODE_GETACK, 8'($urandom), 1'($urandom_range(1)), SDA_RANDOM, 10);
					end else begin
						bus_command(MODE_READ, 8'($urandom), 1'($urandom_range(1)), SDA_RANDOM, 10);
						bus_command(MODE_PUTACK, 8'($urandom), 1'($urandom_range(1)), SDA_RANDOM, 10);
					end
				end
				bus_command(MODE_STOP, 8'($urandom), 1'($urandom_range(1)), SDA_RANDOM, 10);
			end
		end
	endtask

	// Change the unit length once every expected result word has come back.
	task automatic set_delay(input logic [15:0] ticks);
		cmd_ch.valid <= 1'b0;
		do @(posedge clk); while (words_in_flight != 0);
		cfg_we    <= 1'b1;
		cfg_wdata <= ticks;
		@(posedge clk);
		cfg_we <= 1'b0;
		ticks_per_unit = (ticks == 16'd0) ? 1 : ticks;
	endtask

	// Stimulus and verdict.
	initial begin
		cmd_ch.valid       <= 1'b0;
		cmd_ch.cmd_valid   <= 1'b0;
		cmd_ch.mode        <= MODE_START;
		cmd_ch.tx_byte     <= 8'd0;
		cmd_ch.ack_to_send <= 1'b0;
		cmd_ch.sda_in      <= 1'b1;
		cfg_we             <= 1'b0;
		cfg_wdata          <= 16'd0;
		@(posedge arst_n);
		@(posedge clk);

		// One start condition at the unit length left by reset.
		bus_command(MODE_START, 8'h00, 1'b0, SDA_HIGH, 0);

		// Directed commands at one tick per unit: every command, byte extremes,
		// both acknowledge levels, requests while busy and undefined modes.
		set_delay(16'd1);
		bus_command(MODE_START, 8'h00, 1'b0, SDA_RANDOM, 0);
		bus_command(MODE_WRITE, 8'hA5, 1'b1, SDA_RANDOM, 100);
		bus_command(MODE_GETACK, 8'hFF, 1'b1, SDA_LOW, 0);
		bus_command(MODE_WRITE, 8'h00, 1'b0, SDA_RANDOM, 0);
		bus_command(MODE_GETACK, 8'h00, 1'b0, SDA_HIGH, 0);
		bus_command(MODE_WRITE, 8'hFF, 1'b1, SDA_RANDOM, 0);
		bus_command(MODE_READ, 8'h5A, 1'b1, SDA_HIGH, 0);
		bus_command(MODE_PUTACK, 8'h00, 1'b0, SDA_RANDOM, 0);
		bus_command(MODE_READ, 8'hFF, 1'b0, SDA_LOW, 0);
		bus_command(MODE_PUTACK, 8'hFF, 1'b1, SDA_RANDOM, 0);
		bus_command(MODE_READ, 8'h3C, 1'b0, SDA_RANDOM, 0);
		bus_command(MODE_GETACK, 8'h81, 1'b0, SDA_RANDOM, 0);
		bus_command(MODE_STOP, 8'h00, 1'b0, SDA_RANDOM, 0);
		bus_command(MODE_UNDEF_A, 8'hFF, 1'b1, SDA_HIGH, 0);
		bus_command(MODE_UNDEF_B, 8'h00, 1'b0, SDA_LOW, 0);
		bus_command(MODE_STOP, 8'hFF, 1'b1, SDA_HIGH, 0);
		stray_words(4);

		// Random transfers across several unit lengths, zero among them; stray words at the maximum.
		random_transfers(300);
		set_delay(16'd2);
		random_transfers(150);
		set_delay(16'd3);
		random_transfers(120);
		set_delay(16'd0);
		random_transfers(120);
		set_delay(16'hFFFF);
		stray_words(60);
		// A short unit after a long count cuts the current unit at once.
		set_delay(16'd1);
		stray_words(100);

		// Drain, settle and report.
		cmd_ch.valid <= 1'b0;
		do @(posedge clk); while (words_in_flight != 0);
		repeat (SETTLE) @(posedge clk);
		if (fail_count == 0 && words_in_flight == 0) begin
			$display("i2c_bit_bang_master_tb OK");
		end else begin
			$display("i2c_bit_bang_master_tb NOT OK");
		end
		$finish;
	end

endmodule
